// ===== rtl/core/rgba_alpha_blend_over_core_defines.svh =====
// Assertion macros for the alpha blend core.
// Each macro expects clk and rst_n in scope.
`ifndef RGBA_ALPHA_BLEND_OVER_CORE_DEFINES_SVH
`define RGBA_ALPHA_BLEND_OVER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ABO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ABO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/abo_pkg.sv =====
package abo_pkg;

    localparam int unsigned ChanNum    = 3;
    localparam int unsigned NumWidth   = 17;
    localparam int unsigned QuotWidth  = 8;
    localparam int unsigned PipeDepth  = 8;
    localparam int unsigned DivRegs    = 4;
    localparam logic [7:0]  ChanMax    = 8'hFF;

    // Stage 1: alpha product and foreground products
    typedef struct packed {
        logic [7:0]                   alpha_f;
        logic [15:0]                  w_back;
        logic [ChanNum-1:0][15:0]     fore_prod;
        logic [ChanNum-1:0][7:0]      back_chan;
    } s1_t;

    // Stage 2: background products, first estimate of w / 255
    typedef struct packed {
        logic [7:0]                   alpha_f;
        logic [15:0]                  w_back;
        logic [15:0]                  w_est;
        logic [ChanNum-1:0][15:0]     fore_prod;
        logic [ChanNum-1:0][23:0]     back_prod;
    } s2_t;

    // Stage 3: output alpha, estimates of the background terms
    typedef struct packed {
        logic [7:0]                   alpha_p;
        logic [ChanNum-1:0][15:0]     fore_prod;
        logic [ChanNum-1:0][23:0]     back_prod;
        logic [ChanNum-1:0][15:0]     back_est;
    } s3_t;

    // Divider stages: partial remainder and quotient per channel
    typedef struct packed {
        logic [7:0]                         alpha_p;
        logic [ChanNum-1:0][NumWidth-1:0]   rem;
        logic [ChanNum-1:0][QuotWidth-1:0]  quot;
        logic [ChanNum-1:0]                 clip;
    } div_t;

    // First guess of floor(x / 255); low by at most one
    function automatic logic [15:0] div255_est(input logic [23:0] x);
        logic [24:0] sum;
        sum = 25'(x) + 25'(x >> 8) + 25'(x >> 16);
        return sum[23:8];
    endfunction

    // Correct the guess with one compare of the remainder
    function automatic logic [15:0] div255_fix(input logic [23:0] x, input logic [15:0] q);
        logic [24:0] prod;
        logic [24:0] r;
        prod = 25'({q, 8'h00}) - 25'(q);
        r    = 25'(x) - prod;
        return (r >= 25'(ChanMax)) ? q + 16'd1 : q;
    endfunction

    // One restoring division step at bit position pos
    function automatic div_t div_step(input div_t d, input logic [2:0] pos);
        div_t            o;
        logic [NumWidth-1:0] den;
        o   = d;
        den = NumWidth'(d.alpha_p) << pos;
        for (int c = 0; c < ChanNum; c++)
        begin
            if (d.rem[c] >= den)
            begin
                o.rem[c]       = d.rem[c] - den;
                o.quot[c][pos] = 1'b1;
            end
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/rgba_alpha_blend_over_core.sv =====
// Alpha "over" compositing of one ARGB8888 foreground pixel onto one
// ARGB8888 background pixel (alpha 31:24, red 23:16, green 15:8, blue 7:0).
// Input word: fore_pixel and back_pixel, taken at an edge where in_valid is
// high and in_stall is low. Output word: blended_pixel, zero_alpha and
// clipped, taken at an edge where out_valid is high and out_stall is low.
// Throughput: one word per cycle while out_stall is low, through an
// eight-register pipeline: products, divide-by-255 estimate and fix,
// then a restoring divider by the output alpha that resolves two
// quotient bits per stage. A word passes s1, s2, s3, the divider
// registers and the result register in order before out_valid rises.
// A channel quotient above 255 saturates to 255 and sets clipped; a zero
// output alpha gives an all-zero pixel with zero_alpha set.
// Stall: each stage holds while the stage after it is full and held, so
// bubbles close up; in_stall rises only when all eight stages are full
// and out_stall is high. No word is lost or repeated.
// Reset: clears all valid bits; the pipeline comes up empty.
`include "rgba_alpha_blend_over_core_defines.svh"

module rgba_alpha_blend_over_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] fore_pixel,
    input  logic [31:0] back_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] blended_pixel,
    output logic        zero_alpha,
    output logic        clipped
);

    logic [abo_pkg::PipeDepth-1:0] vld_reg;
    logic [abo_pkg::PipeDepth-1:0] adv;

    abo_pkg::s1_t  s1_reg, s1_next;
    abo_pkg::s2_t  s2_reg, s2_next;
    abo_pkg::s3_t  s3_reg, s3_next;
    abo_pkg::div_t div_reg [abo_pkg::DivRegs];
    abo_pkg::div_t div0_next;
    abo_pkg::div_t last_div;

    logic [31:0] pixel_reg, pixel_next;
    logic        zero_reg, zero_next;
    logic        clip_reg, clip_next;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        adv[abo_pkg::PipeDepth-1] = !vld_reg[abo_pkg::PipeDepth-1] || !out_stall;
        for (int k = abo_pkg::PipeDepth - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_stall = !adv[0];

    // Move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < abo_pkg::PipeDepth; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: alpha weight of the background and foreground products
    always_comb
    begin
        logic [7:0] af;
        logic [7:0] ab;
        logic [7:0] naf;
        af  = fore_pixel[31:24];
        ab  = back_pixel[31:24];
        naf = abo_pkg::ChanMax - af;
        s1_next.alpha_f = af;
        s1_next.w_back  = 16'(ab) * 16'(naf);
        for (int c = 0; c < abo_pkg::ChanNum; c++)
        begin
            s1_next.fore_prod[c] = 16'(fore_pixel[8*c +: 8]) * 16'(af);
            s1_next.back_chan[c] = back_pixel[8*c +: 8];
        end
    end

    // Stage 2: background products, estimate of the alpha term
    always_comb
    begin
        s2_next.alpha_f   = s1_reg.alpha_f;
        s2_next.w_back    = s1_reg.w_back;
        s2_next.w_est     = abo_pkg::div255_est({8'h00, s1_reg.w_back});
        s2_next.fore_prod = s1_reg.fore_prod;
        for (int c = 0; c < abo_pkg::ChanNum; c++)
        begin
            s2_next.back_prod[c] = 24'(s1_reg.back_chan[c]) * 24'(s1_reg.w_back);
        end
    end

    // Stage 3: output alpha, estimate of the background terms
    always_comb
    begin
        logic [15:0] wq;
        wq = abo_pkg::div255_fix({8'h00, s2_reg.w_back}, s2_reg.w_est);
        s3_next.alpha_p   = s2_reg.alpha_f + wq[7:0];
        s3_next.fore_prod = s2_reg.fore_prod;
        s3_next.back_prod = s2_reg.back_prod;
        for (int c = 0; c < abo_pkg::ChanNum; c++)
        begin
            s3_next.back_est[c] = abo_pkg::div255_est(s2_reg.back_prod[c]);
        end
    end

    // Stage 4: fix the background terms and form the numerators
    always_comb
    begin
        logic [15:0] bq;
        div0_next.alpha_p = s3_reg.alpha_p;
        div0_next.quot    = '0;
        div0_next.clip    = '0;
        for (int c = 0; c < abo_pkg::ChanNum; c++)
        begin
            bq = abo_pkg::div255_fix(s3_reg.back_prod[c], s3_reg.back_est[c]);
            div0_next.rem[c] = abo_pkg::NumWidth'(s3_reg.fore_prod[c])
                             + abo_pkg::NumWidth'(bq);
        end
    end

    // Load the front stages
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= s1_next;
        end
        if (adv[1])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2])
        begin
            s3_reg <= s3_next;
        end
        if (adv[3])
        begin
            div_reg[0] <= div0_next;
        end
    end

    // Divider stages: two quotient bits each; the first also flags overflow
    for (genvar k = 0; k < abo_pkg::DivRegs - 1; k++)
    begin : g_div
        abo_pkg::div_t step_a;
        abo_pkg::div_t step_b;

        always_comb
        begin
            step_a = div_reg[k];
            if (k == 0)
            begin
                for (int c = 0; c < abo_pkg::ChanNum; c++)
                begin
                    step_a.clip[c] = div_reg[k].rem[c]
                                   >= abo_pkg::NumWidth'({div_reg[k].alpha_p, 8'h00});
                end
            end
            step_a = abo_pkg::div_step(step_a, 3'(7 - 2*k));
            step_b = abo_pkg::div_step(step_a, 3'(6 - 2*k));
        end

        always_ff @(posedge clk)
        begin
            if (adv[4+k])
            begin
                div_reg[k+1] <= step_b;
            end
        end
    end

    // Last stage: final two bits, saturate and pack
    always_comb
    begin
        logic [abo_pkg::ChanNum-1:0][7:0] chan;
        last_div = abo_pkg::div_step(div_reg[abo_pkg::DivRegs-1], 3'd1);
        last_div = abo_pkg::div_step(last_div, 3'd0);
        for (int c = 0; c < abo_pkg::ChanNum; c++)
        begin
            chan[c] = last_div.clip[c] ? abo_pkg::ChanMax : last_div.quot[c];
        end
        zero_next = (last_div.alpha_p == 8'h00);
        if (zero_next)
        begin
            pixel_next = '0;
            clip_next  = 1'b0;
        end
        else
        begin
            pixel_next = {last_div.alpha_p, chan[2], chan[1], chan[0]};
            clip_next  = |last_div.clip;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (adv[abo_pkg::PipeDepth-1])
        begin
            pixel_reg <= pixel_next;
            zero_reg  <= zero_next;
            clip_reg  <= clip_next;
        end
    end

    assign out_valid     = vld_reg[abo_pkg::PipeDepth-1];
    assign blended_pixel = pixel_reg;
    assign zero_alpha    = zero_reg;
    assign clipped       = clip_reg;

    // Checks
    `ABO_ASSERT_NOW(a_stall_full, in_stall, (&vld_reg) && out_stall,
        "input stalled with room in pipe")
    `ABO_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld_reg[0],
        "accepted word not captured")
    `ABO_ASSERT_NOW(a_zero_clean, out_valid && zero_alpha,
        blended_pixel == 32'h0 && !clipped, "zero alpha word not cleared")
    `ABO_ASSERT_NOW(a_alpha_nonzero, out_valid && !zero_alpha,
        blended_pixel[31:24] != 8'h00, "nonzero word with zero alpha")

endmodule

// ===== bench/rgba_alpha_blend_over_core_tb.sv =====
`timescale 1ns / 1ps

module rgba_alpha_blend_over_core_tb;

    localparam int unsigned ChanFull    = 255;
    localparam int unsigned IdlePct     = 36;
    localparam int unsigned DrainCycles = 16;
    localparam int unsigned HoldCycles  = 60;

    typedef struct {
        logic [31:0] pixel;
        logic        zero;
        logic        clip;
    } blend_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [31:0] fore_pixel    = '0;
    logic [31:0] back_pixel    = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [31:0] blended_pixel;
    logic        zero_alpha;
    logic        clipped;

    blend_t      expected_blends[$];
    int unsigned mismatch_count = 0;
    bit          sender_gaps    = 1'b1;
    bit          receiver_gaps  = 1'b1;
    int unsigned hold_req       = 0;
    int unsigned hold_left      = 0;

    rgba_alpha_blend_over_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .fore_pixel    (fore_pixel),
        .back_pixel    (back_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blended_pixel (blended_pixel),
        .zero_alpha    (zero_alpha),
        .clipped       (clipped)
    );

    always #5 clk = ~clk;

    // Composite fore over back with floored integer math, saturating channels
    function automatic blend_t blend_over(input logic [31:0] fore, input logic [31:0] back);
        int unsigned af;
        int unsigned ab;
        int unsigned ap;
        int unsigned num;
        int unsigned quot;
        blend_t      res;
        af  = int'(fore[31:24]);
        ab  = int'(back[31:24]);
        ap  = af + (ab * (ChanFull - af)) / ChanFull;
        res = '{pixel: '0, zero: 1'b0, clip: 1'b0};
        if (ap == 0)
        begin
            res.zero = 1'b1;
            return res;
        end
        res.pixel[31:24] = ap[7:0];
        for (int c = 0; c < 3; c++)
        begin
            num  = int'(fore[c*8 +: 8]) * af
                 + (int'(back[c*8 +: 8]) * ab * (ChanFull - af)) / ChanFull;
            quot = num / ap;
            if (quot > ChanFull)
            begin
                quot     = ChanFull;
                res.clip = 1'b1;
            end
            res.pixel[c*8 +: 8] = quot[7:0];
        end
        return res;
    endfunction

    // Pick an alpha, leaning toward the edges and the low values that clip
    function automatic logic [7:0] rand_alpha();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom_range(1, 4));
            4:       return 8'($urandom_range(251, 254));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        px = $urandom();
        case ($urandom_range(0, 9))
            0:       px[23:0] = 24'hFFFFFF;
            1:       px[23:0] = 24'h000000;
            2, 3, 4: px[31:24] = rand_alpha();
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one word, hold it until taken, then maybe idle at random
    task automatic send_pixels(input logic [31:0] fore, input logic [31:0] back);
        in_valid   <= 1'b1;
        fore_pixel <= fore;
        back_pixel <= back;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_blends.push_back(blend_over(fore, back));
        @(negedge clk);
        while (sender_gaps && ($urandom_range(99) < IdlePct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_blends.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Receiver: honor a hold-off request first, else stall at random
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= receiver_gaps && ($urandom_range(99) < IdlePct);
    end

    // Check each taken word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_blends.size() == 0)
                report_mismatch("unexpected word", blended_pixel, '0);
            else
            begin
                blend_t want;
                want = expected_blends.pop_front();
                if (blended_pixel !== want.pixel)
                    report_mismatch("blended_pixel", blended_pixel, want.pixel);
                if (zero_alpha !== want.zero)
                    report_mismatch("zero_alpha", 32'(zero_alpha), 32'(want.zero));
                if (clipped !== want.clip)
                    report_mismatch("clipped", 32'(clipped), 32'(want.clip));
            end
        end
    end

    task automatic test_zero_alpha();
        send_pixels(32'h00000000, 32'h00000000);
        send_pixels(32'h00FFFFFF, 32'h00FFFFFF);
        send_pixels(32'h00123456, 32'h00ABCDEF);
        send_pixels(32'h00FF00FF, 32'h0000FF00);
    endtask

    task automatic test_opaque_and_clear();
        send_pixels(32'hFFFFFFFF, 32'h00000000);
        send_pixels(32'hFF000000, 32'hFFFFFFFF);
        send_pixels(32'hFF123456, 32'h80ABCDEF);
        send_pixels(32'h00FFFFFF, 32'hFF102030);
        send_pixels(32'h00000000, 32'hFFFFFFFF);
        send_pixels(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixels(32'hFF000000, 32'hFF000000);
        send_pixels(32'h80FF0000, 32'h800000FF);
        send_pixels(32'h7F00FF00, 32'hFF00FF00);
        send_pixels(32'h01000000, 32'hFEFFFFFF);
    endtask

    // Low alphas: floors before the divide push the quotient past full scale
    task automatic test_clipping();
        send_pixels(32'h00000000, 32'h01FFFFFF);
        send_pixels(32'h01FFFFFF, 32'h01FFFFFF);
        send_pixels(32'h02FFFFFF, 32'h03FFFFFF);
        send_pixels(32'h01FF00FF, 32'h01FF00FF);
        send_pixels(32'h0180FF40, 32'h04FFFFFF);
    endtask

    task automatic test_random_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_pixels(rand_pixel(), rand_pixel());
            if (i % 200 == 199)
                wait_drain();
        end
    endtask

    // Back-to-back words with both sides always ready
    task automatic test_full_rate_stream(input int unsigned count);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        for (int unsigned i = 0; i < count; i++)
            send_pixels(rand_pixel(), rand_pixel());
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // Hold the output long enough that the pipeline fills and stalls its input
    task automatic test_output_holdoff(input int unsigned count);
        sender_gaps = 1'b0;
        hold_req    = HoldCycles;
        for (int unsigned i = 0; i < count; i++)
            send_pixels(rand_pixel(), rand_pixel());
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_alpha();
        test_opaque_and_clear();
        test_clipping();
        wait_drain();
        test_random_pixels(600);
        wait_drain();
        test_full_rate_stream(120);
        wait_drain();
        test_output_holdoff(40);
        wait_drain();

        if (mismatch_count == 0)
            $display("rgba_alpha_blend_over_core_tb: PASS");
        else
            $display("rgba_alpha_blend_over_core_tb: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("rgba_alpha_blend_over_core_tb: FAIL");
        $finish;
    end

endmodule
